>>> rtl/tsiw_pkg.sv
// Package with the constants, types and helper functions of the tile scoreboard issue window.
package tsiw_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int NUM_TILES = 32;
    localparam int NUM_REGS  = 32;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [5:0] NO_TILE = 6'h3F;

    localparam logic [2:0] ST_WFI = 3'd0;
    localparam logic [2:0] ST_INV = 3'd1;
    localparam logic [2:0] ST_WFS = 3'd2;
    localparam logic [2:0] ST_SRV = 3'd3;
    localparam logic [2:0] ST_FIN = 3'd4;

    localparam logic [2:0] CMD_PUSH   = 3'd0;
    localparam logic [2:0] CMD_REGCHK = 3'd1;
    localparam logic [2:0] CMD_READY  = 3'd2;
    localparam logic [2:0] CMD_FINCMP = 3'd3;
    localparam logic [2:0] CMD_FININV = 3'd4;

    localparam logic [2:0] UNIT_INVAL = 3'd4;

    localparam logic [1:0] RSN_NONE   = 2'd0;
    localparam logic [1:0] RSN_HAZARD = 2'd1;
    localparam logic [1:0] RSN_FULL   = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPLY,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        OPN_NONE,
        OPN_PUSH,
        OPN_RETAG,
        OPN_ISSUE,
        OPN_FREE,
        OPN_IDLE
    } cell_op_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        cell_op_t          op;
        logic [SLOT_W-1:0] sel;
        logic [1:0]        unit;
        logic [29:0]       tiles;
        logic [31:0]       mask;
        logic [5:0]        tile_a;
        logic [5:0]        tile_b;
        logic [4:0]        ops;
        logic              need_from;
        logic [2:0]        from;
        logic [2:0]        to;
        logic [5:0]        pend;
    } cell_ctl_t;

    // Per-cell observation seen by the controller.
    typedef struct packed {
        logic       valid;
        logic       hazard;
        logic       reg_used;
        logic       comp_ready;
        logic [5:0] inv_tile;
        logic [5:0] pend;
        logic [5:0] dst1;
        logic [5:0] dst2;
    } cell_obs_t;

    function automatic logic [5:0] tile_in(input logic [5:0] raw);
        if (raw[5] || raw >= 6'(NUM_TILES))
            return NO_TILE;
        return raw;
    endfunction

    function automatic logic has_tile(input logic [5:0] t);
        return t < 6'(NUM_TILES);
    endfunction

endpackage

>>> rtl/tile_scoreboard_issue_window_top.sv
// Top level of the tile scoreboard issue window: sequencer plus a row of slot cells.
//
// A command beat is taken at a rising edge where start is high and busy is low.
// Each command yields one result beat: done is high for exactly one cycle while
// ok, reject_reason, slot_out and inval_tile hold the result. The receiver
// cannot stall, so the result must be taken in that cycle.
// The sequencer visits one slot cell per cycle through a shared query bus.
// Push, register check and an unsuccessful get-ready scan every slot, then take
// an apply step before the result cycle; a push with an unknown opcode ends its
// scan at once. A successful get-ready stops at the first ready slot and adds a
// second apply step for the status broadcast, as does a finish on a found slot.
// Finish and unknown commands read only the indexed slot instead of scanning. busy stays
// high until the result cycle ends, and a new command may be accepted in the next cycle.
// Reset clears every slot's valid bit, the rotating start pointer and the
// sequencer; no clearing pass is needed, so the block is ready right after reset.
module tile_scoreboard_issue_window_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  command,
    input  logic [3:0]  opcode,
    input  logic [5:0]  src1_tile,
    input  logic [5:0]  src2_tile,
    input  logic [5:0]  cond_tile,
    input  logic [5:0]  dst1_tile,
    input  logic [5:0]  dst2_tile,
    input  logic [31:0] reg_use_mask,
    input  logic [4:0]  index,
    input  logic [2:0]  unit_kind,
    input  logic [1:0]  fin_status,
    output logic        done,
    output logic        ok,
    output logic [1:0]  reject_reason,
    output logic [4:0]  slot_out,
    output logic [5:0]  inval_tile
);
    import tsiw_pkg::*;

    cell_ctl_t  ctl;
    cell_obs_t  obs [NUM_SLOTS];
    logic [5:0] q_d1, q_d2;
    logic [4:0] q_reg;
    logic [1:0] q_unit;

    tsiw_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .command(command), .opcode(opcode),
        .src1_tile(src1_tile), .src2_tile(src2_tile), .cond_tile(cond_tile),
        .dst1_tile(dst1_tile), .dst2_tile(dst2_tile),
        .reg_use_mask(reg_use_mask), .index(index), .unit_kind(unit_kind),
        .fin_status(fin_status), .obs(obs), .ctl(ctl),
        .q_d1(q_d1), .q_d2(q_d2), .q_reg(q_reg), .q_unit(q_unit),
        .done(done), .ok(ok), .reject_reason(reject_reason),
        .slot_out(slot_out), .inval_tile(inval_tile)
    );

    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        tsiw_cell u_cell (
            .clk(clk), .rst_n(rst_n), .my_slot(SLOT_W'(i)), .ctl(ctl),
            .q_d1(q_d1), .q_d2(q_d2), .q_reg(q_reg), .q_unit(q_unit),
            .obs(obs[i])
        );
    end

endmodule

>>> rtl/tsiw_cell.sv
// One window slot: holds an entry, answers queries and applies broadcast updates.
module tsiw_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [tsiw_pkg::SLOT_W-1:0] my_slot,
    input  tsiw_pkg::cell_ctl_t ctl,
    input  logic [5:0]          q_d1,
    input  logic [5:0]          q_d2,
    input  logic [4:0]          q_reg,
    input  logic [1:0]          q_unit,
    output tsiw_pkg::cell_obs_t obs
);
    import tsiw_pkg::*;

    logic        valid_reg, valid_next;
    logic        busy_reg, busy_next;
    logic [1:0]  unit_reg, unit_next;
    logic [29:0] tiles_reg, tiles_next;
    logic [14:0] stat_reg, stat_next;
    logic [31:0] mask_reg, mask_next;
    logic [5:0]  pend_reg, pend_next;

    logic [5:0] tl [5];
    logic [2:0] st [5];
    logic       mine;
    logic       use1, use2;
    logic       rdy;
    logic [5:0] inv;
    logic [2:0] ord [5];

    always_comb
    begin
        for (int k = 0; k < 5; k++)
        begin
            tl[k] = tiles_reg[6*k +: 6];
            st[k] = stat_reg[3*k +: 3];
        end
        mine = (ctl.sel == my_slot);
        use1 = 1'b0;
        use2 = 1'b0;
        for (int k = 0; k < 5; k++)
        begin
            if (has_tile(q_d1) && tl[k] == q_d1)
                use1 = 1'b1;
            if (has_tile(q_d2) && tl[k] == q_d2)
                use2 = 1'b1;
        end
        rdy = !busy_reg && unit_reg == q_unit;
        for (int k = 0; k < 3; k++)
            if (has_tile(tl[k]) && st[k] != ST_SRV && st[k] != ST_FIN)
                rdy = 1'b0;
        for (int k = 3; k < 5; k++)
            if (has_tile(tl[k]) && st[k] != ST_WFS)
                rdy = 1'b0;
        ord[0] = 3'd3;
        ord[1] = 3'd4;
        ord[2] = 3'd0;
        ord[3] = 3'd1;
        ord[4] = 3'd2;
        inv = NO_TILE;
        for (int k = 4; k >= 0; k--)
            if (has_tile(tl[ord[k]]) && st[ord[k]] == ST_WFI)
                inv = tl[ord[k]];
        if (busy_reg)
            inv = NO_TILE;

        obs.valid      = valid_reg;
        obs.hazard     = valid_reg && (use1 || use2);
        obs.reg_used   = valid_reg && mask_reg[q_reg];
        obs.comp_ready = valid_reg && rdy;
        obs.inv_tile   = valid_reg ? inv : NO_TILE;
        obs.pend       = pend_reg;
        obs.dst1       = tl[3];
        obs.dst2       = tl[4];

        valid_next = valid_reg;
        busy_next  = busy_reg;
        unit_next  = unit_reg;
        tiles_next = tiles_reg;
        stat_next  = stat_reg;
        mask_next  = mask_reg;
        pend_next  = pend_reg;
        case (ctl.op)
            OPN_PUSH:
            begin
                if (mine)
                begin
                    valid_next = 1'b1;
                    busy_next  = 1'b0;
                    unit_next  = ctl.unit;
                    tiles_next = ctl.tiles;
                    stat_next  = '0;
                    mask_next  = ctl.mask;
                    pend_next  = NO_TILE;
                end
            end
            OPN_RETAG:
            begin
                if (valid_reg)
                    for (int k = 0; k < 5; k++)
                        if (ctl.ops[k] &&
                            ((has_tile(ctl.tile_a) && tl[k] == ctl.tile_a) ||
                             (has_tile(ctl.tile_b) && tl[k] == ctl.tile_b)) &&
                            (!ctl.need_from || st[k] == ctl.from))
                            stat_next[3*k +: 3] = ctl.to;
            end
            OPN_ISSUE:
            begin
                if (mine)
                begin
                    busy_next = 1'b1;
                    if (has_tile(ctl.pend))
                        pend_next = ctl.pend;
                end
            end
            OPN_FREE:
            begin
                if (mine)
                    valid_next = 1'b0;
            end
            OPN_IDLE:
            begin
                if (mine)
                    busy_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        busy_reg  <= busy_next;
        unit_reg  <= unit_next;
        tiles_reg <= tiles_next;
        stat_reg  <= stat_next;
        mask_reg  <= mask_next;
        pend_reg  <= pend_next;
    end

endmodule

>>> rtl/tsiw_ctrl.sv
// Command sequencer: scans the cells one per cycle and issues broadcast updates.
module tsiw_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [2:0]          command,
    input  logic [3:0]          opcode,
    input  logic [5:0]          src1_tile,
    input  logic [5:0]          src2_tile,
    input  logic [5:0]          cond_tile,
    input  logic [5:0]          dst1_tile,
    input  logic [5:0]          dst2_tile,
    input  logic [31:0]         reg_use_mask,
    input  logic [4:0]          index,
    input  logic [2:0]          unit_kind,
    input  logic [1:0]          fin_status,
    input  tsiw_pkg::cell_obs_t obs [tsiw_pkg::NUM_SLOTS],
    output tsiw_pkg::cell_ctl_t ctl,
    output logic [5:0]          q_d1,
    output logic [5:0]          q_d2,
    output logic [4:0]          q_reg,
    output logic [1:0]          q_unit,
    output logic                done,
    output logic                ok,
    output logic [1:0]          reject_reason,
    output logic [4:0]          slot_out,
    output logic [5:0]          inval_tile
);
    import tsiw_pkg::*;

    localparam int CNT_W = $clog2(NUM_SLOTS + 1);

    state_t            state_reg, state_next;
    logic [2:0]        cmd_reg, cmd_next;
    logic [3:0]        opc_reg, opc_next;
    logic [29:0]       tiles_reg, tiles_next;
    logic [31:0]       mask_reg, mask_next;
    logic [4:0]        idx_reg, idx_next;
    logic [2:0]        unit_reg, unit_next;
    logic [1:0]        ts_reg, ts_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic [SLOT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              found_reg, found_next;
    logic              hz_reg, hz_next;
    logic              free_reg, free_next;
    logic [SLOT_W-1:0] fslot_reg, fslot_next;
    logic [5:0]        itile_reg, itile_next;
    logic [1:0]        phase_reg, phase_next;
    logic              ok_reg, ok_next;
    logic [1:0]        rsn_reg, rsn_next;
    logic [4:0]        slot_reg, slot_next;
    logic [5:0]        inv_reg, inv_next;
    logic              done_reg, done_next;

    logic [1:0]        pu;
    logic              pu_ok;
    logic [SLOT_W-1:0] cur_inc;
    logic              idx_ok;
    cell_obs_t         co;
    cell_obs_t         io;

    assign q_d1   = tiles_reg[23:18];
    assign q_d2   = tiles_reg[29:24];
    assign q_reg  = idx_reg;
    assign q_unit = unit_reg[1:0];
    assign busy   = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign ok            = ok_reg;
    assign reject_reason = rsn_reg;
    assign slot_out      = slot_reg;
    assign inval_tile    = inv_reg;

    always_comb
    begin
        pu_ok = 1'b1;
        pu    = 2'd0;
        if (opc_reg <= 4'd1)
            pu = 2'd0;
        else if (opc_reg <= 4'd6)
            pu = 2'd1;
        else if (opc_reg == 4'd7)
            pu = 2'd2;
        else if (opc_reg <= 4'd10)
            pu = 2'd3;
        else
            pu_ok = 1'b0;

        cur_inc = (cur_reg == SLOT_W'(NUM_SLOTS - 1)) ? '0 : cur_reg + 1'b1;
        co      = obs[cur_reg];
        idx_ok  = (32'(idx_reg) < NUM_SLOTS);
        io      = obs[idx_reg[SLOT_W-1:0]];

        state_next = state_reg;
        cmd_next   = cmd_reg;
        opc_next   = opc_reg;
        tiles_next = tiles_reg;
        mask_next  = mask_reg;
        idx_next   = idx_reg;
        unit_next  = unit_reg;
        ts_next    = ts_reg;
        ptr_next   = ptr_reg;
        cur_next   = cur_reg;
        cnt_next   = cnt_reg;
        found_next = found_reg;
        hz_next    = hz_reg;
        free_next  = free_reg;
        fslot_next = fslot_reg;
        itile_next = itile_reg;
        phase_next = phase_reg;
        ok_next    = ok_reg;
        rsn_next   = rsn_reg;
        slot_next  = slot_reg;
        inv_next   = inv_reg;
        done_next  = 1'b0;
        ctl        = '0;
        ctl.op     = OPN_NONE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next   = command;
                    opc_next   = opcode;
                    tiles_next = {tile_in(dst2_tile), tile_in(dst1_tile), tile_in(cond_tile),
                                  tile_in(src2_tile), tile_in(src1_tile)};
                    mask_next  = (NUM_REGS >= 32) ? reg_use_mask :
                                 reg_use_mask & ((32'd1 << NUM_REGS) - 32'd1);
                    idx_next   = index;
                    unit_next  = unit_kind;
                    ts_next    = fin_status;
                    cnt_next   = '0;
                    found_next = 1'b0;
                    hz_next    = 1'b0;
                    free_next  = 1'b0;
                    phase_next = 2'd0;
                    cur_next   = (command == CMD_READY) ? ptr_reg : '0;
                    if (command == CMD_READY)
                        ptr_next = (ptr_reg == SLOT_W'(NUM_SLOTS - 1)) ? '0 : ptr_reg + 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cur_next = cur_inc;
                cnt_next = cnt_reg + 1'b1;
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (!pu_ok)
                            state_next = S_APPLY;
                        else
                        begin
                            if (!co.valid && !free_reg)
                            begin
                                free_next  = 1'b1;
                                fslot_next = cur_reg;
                            end
                            if (co.hazard)
                                hz_next = 1'b1;
                            if (cnt_reg == CNT_W'(NUM_SLOTS - 1))
                                state_next = S_APPLY;
                        end
                    end
                    CMD_REGCHK:
                    begin
                        if (co.reg_used)
                            hz_next = 1'b1;
                        if (cnt_reg == CNT_W'(NUM_SLOTS - 1))
                            state_next = S_APPLY;
                    end
                    CMD_READY:
                    begin
                        if (unit_reg == UNIT_INVAL && has_tile(co.inv_tile))
                        begin
                            found_next = 1'b1;
                            fslot_next = cur_reg;
                            itile_next = co.inv_tile;
                            state_next = S_APPLY;
                        end
                        else if (unit_reg < UNIT_INVAL && co.comp_ready)
                        begin
                            found_next = 1'b1;
                            fslot_next = cur_reg;
                            itile_next = NO_TILE;
                            tiles_next = {co.dst2, co.dst1, 18'd0};
                            state_next = S_APPLY;
                        end
                        else if (cnt_reg == CNT_W'(NUM_SLOTS - 1))
                            state_next = S_APPLY;
                    end
                    default:
                    begin
                        fslot_next = idx_reg[SLOT_W-1:0];
                        itile_next = io.pend;
                        tiles_next = {io.dst2, io.dst1, 18'd0};
                        found_next = idx_ok && io.valid &&
                                     (cmd_reg == CMD_FINCMP ||
                                      (cmd_reg == CMD_FININV && ts_reg <= 2'd2));
                        state_next = S_APPLY;
                    end
                endcase
            end
            S_APPLY:
            begin
                ok_next   = 1'b0;
                rsn_next  = RSN_NONE;
                slot_next = '0;
                inv_next  = NO_TILE;
                ctl.sel   = fslot_reg;
                state_next = S_DONE;
                case (cmd_reg)
                    CMD_PUSH:
                    begin
                        if (!pu_ok)
                            ok_next = 1'b0;
                        else if (hz_reg)
                            rsn_next = RSN_HAZARD;
                        else if (!free_reg)
                            rsn_next = RSN_FULL;
                        else
                        begin
                            ctl.op    = OPN_PUSH;
                            ctl.unit  = pu;
                            ctl.tiles = tiles_reg;
                            ctl.mask  = mask_reg;
                            ok_next   = 1'b1;
                            slot_next = 5'(fslot_reg);
                        end
                    end
                    CMD_REGCHK:
                        ok_next = !hz_reg;
                    CMD_READY:
                    begin
                        if (found_reg)
                        begin
                            ok_next   = 1'b1;
                            slot_next = 5'(fslot_reg);
                            if (unit_reg == UNIT_INVAL)
                            begin
                                inv_next = itile_reg;
                                if (phase_reg == 2'd0)
                                begin
                                    ctl.op     = OPN_ISSUE;
                                    ctl.pend   = itile_reg;
                                    phase_next = 2'd1;
                                    state_next = S_APPLY;
                                end
                                else
                                begin
                                    ctl.op        = OPN_RETAG;
                                    ctl.tile_a    = itile_reg;
                                    ctl.tile_b    = NO_TILE;
                                    ctl.ops       = 5'h1F;
                                    ctl.need_from = 1'b1;
                                    ctl.from      = ST_WFI;
                                    ctl.to        = ST_INV;
                                end
                            end
                            else if (phase_reg == 2'd0)
                            begin
                                ctl.op     = OPN_ISSUE;
                                ctl.pend   = NO_TILE;
                                phase_next = 2'd1;
                                state_next = S_APPLY;
                            end
                            else
                            begin
                                ctl.op     = OPN_RETAG;
                                ctl.tile_a = q_d1;
                                ctl.tile_b = q_d2;
                                ctl.ops    = 5'h1F;
                                ctl.to     = ST_SRV;
                            end
                        end
                    end
                    CMD_FINCMP:
                    begin
                        if (found_reg)
                        begin
                            ok_next   = 1'b1;
                            slot_next = 5'(fslot_reg);
                            if (phase_reg == 2'd0)
                            begin
                                ctl.op     = OPN_FREE;
                                phase_next = 2'd1;
                                state_next = S_APPLY;
                            end
                            else
                            begin
                                ctl.op     = OPN_RETAG;
                                ctl.tile_a = q_d1;
                                ctl.tile_b = q_d2;
                                ctl.ops    = 5'h07;
                                ctl.to     = ST_FIN;
                            end
                        end
                    end
                    CMD_FININV:
                    begin
                        if (found_reg)
                        begin
                            ok_next   = 1'b1;
                            slot_next = 5'(fslot_reg);
                            if (phase_reg == 2'd0)
                            begin
                                ctl.op     = OPN_IDLE;
                                phase_next = 2'd1;
                                state_next = S_APPLY;
                            end
                            else
                            begin
                                ctl.op        = OPN_RETAG;
                                ctl.tile_a    = itile_reg;
                                ctl.tile_b    = NO_TILE;
                                ctl.ops       = 5'h1F;
                                ctl.need_from = 1'b1;
                                ctl.from      = ST_INV;
                                ctl.to        = (ts_reg == 2'd0) ? ST_WFS :
                                                (ts_reg == 2'd1) ? ST_SRV : ST_FIN;
                            end
                        end
                    end
                    default:
                        ok_next = 1'b0;
                endcase
                if (state_next == S_DONE)
                    done_next = 1'b1;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ptr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        opc_reg   <= opc_next;
        tiles_reg <= tiles_next;
        mask_reg  <= mask_next;
        idx_reg   <= idx_next;
        unit_reg  <= unit_next;
        ts_reg    <= ts_next;
        cur_reg   <= cur_next;
        cnt_reg   <= cnt_next;
        found_reg <= found_next;
        hz_reg    <= hz_next;
        free_reg  <= free_next;
        fslot_reg <= fslot_next;
        itile_reg <= itile_next;
        phase_reg <= phase_next;
        ok_reg    <= ok_next;
        rsn_reg   <= rsn_next;
        slot_reg  <= slot_next;
        inv_reg   <= inv_next;
    end

endmodule
